>>> design/lps_pkg.sv
// Lag predictor scoreboard package: sizes, item types, walk state codes and
// the counter and history address helpers.
// No dependencies.
package lps_pkg;

  localparam int MAX_LAG      = 128;
  localparam int SYMBOL_WIDTH = 8;
  localparam int COUNT_WIDTH  = 32;
  localparam int LAG_W        = $clog2(MAX_LAG);
  localparam int FILL_W       = $clog2(MAX_LAG + 1);

  typedef logic [SYMBOL_WIDTH-1:0] sym_t;
  typedef logic [LAG_W-1:0]        lag_t;
  typedef logic [FILL_W-1:0]       fill_t;
  typedef logic [COUNT_WIDTH-1:0]  count_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHK,
    S_WALK,
    S_PUSH
  } state_t;

  // Saturating increment.
  function automatic count_t sat_inc(input count_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Ring slot of the symbol that lies off+1 items back from write pointer wp.
  function automatic lag_t hist_addr(input lag_t wp, input lag_t off);
    logic [LAG_W:0] a;
    if (wp > off) begin
      a = {1'b0, wp} - {1'b0, off} - 1'b1;
    end else begin
      a = {1'b0, wp} + (LAG_W+1)'(MAX_LAG) - {1'b0, off} - 1'b1;
    end
    return a[LAG_W-1:0];
  endfunction

  // Ring write pointer advance.
  function automatic lag_t wp_inc(input lag_t wp);
    return (wp == lag_t'(MAX_LAG - 1)) ? '0 : wp + 1'b1;
  endfunction

endpackage

>>> design/lag_predictor_scoreboard.sv
// Lag predictor scoreboard top level: symbol history ring and lag score memory
// with a sequencer that walks the offsets one per cycle.
// Depends on lps_pkg.
//
// An item with filled history F (1..MAX_LAG) passes S_CHK, S_WALK (offsets
// 0..F-1) and S_PUSH, which waits on a stalled result; the first symbol of a
// sequence goes straight to S_PUSH. in_stall holds further items off until
// S_IDLE. The walk does one score read-modify-write per cycle, on separate
// read and write ports. Reset (rst_n low, synchronous) and start_req clear
// fill level, leader, all counters and 128 score valid bits; no clearing pass.
module lag_predictor_scoreboard (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_sample,
  input  logic        in_start_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [31:0] out_hit_total,
  output logic [31:0] out_best_run,
  output logic [6:0]  out_lead_offset
);
  import lps_pkg::*;

  // Memories: history ring (read-only during walk) and per-offset scores.
  sym_t   hist_mem  [MAX_LAG];
  count_t score_mem [MAX_LAG];

  // Control and counters.
  state_t             state_r, state_nxt;
  fill_t              fill_r, fill_nxt;
  lag_t               wp_r, wp_nxt;
  lag_t               off_r, off_nxt;
  lag_t               leader_r, leader_nxt;
  count_t             lead_score_r, lead_score_nxt;
  count_t             total_r, total_nxt;
  count_t             run_r, run_nxt;
  count_t             best_r, best_nxt;
  logic [MAX_LAG-1:0] valid_r, valid_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Payload registers.
  sym_t   sym_r, sym_nxt;
  logic   hit_r, hit_nxt;
  logic   out_hit_r, out_hit_nxt;
  count_t out_total_r, out_total_nxt;
  count_t out_best_r, out_best_nxt;
  lag_t   out_lead_r, out_lead_nxt;

  // Memory ports.
  logic   hist_re, hist_we;
  lag_t   hist_ra;
  sym_t   hist_rd_r;
  logic   score_re, score_we;
  lag_t   score_ra;
  count_t score_wd;
  count_t score_rd_r;

  // Walk datapath.
  count_t         score_q;
  count_t         score_inc;
  logic           match;
  logic [LAG_W:0] off_inc;
  logic           out_free;

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_hit_total   = 32'(out_total_r);
  assign out_best_run    = 32'(out_best_r);
  assign out_lead_offset = 7'(out_lead_r);

  // Score of an offset never touched since the last clear reads as zero.
  assign score_q   = valid_r[off_r] ? score_rd_r : '0;
  assign score_inc = sat_inc(score_q);
  assign match     = (hist_rd_r == sym_r);
  assign off_inc   = {1'b0, off_r} + 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    wp_nxt         = wp_r;
    off_nxt        = off_r;
    leader_nxt     = leader_r;
    lead_score_nxt = lead_score_r;
    total_nxt      = total_r;
    run_nxt        = run_r;
    best_nxt       = best_r;
    valid_nxt      = valid_r;
    sym_nxt        = sym_r;
    hit_nxt        = hit_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_hit_nxt    = out_hit_r;
    out_total_nxt  = out_total_r;
    out_best_nxt   = out_best_r;
    out_lead_nxt   = out_lead_r;
    hist_re        = 1'b0;
    hist_we        = 1'b0;
    hist_ra        = hist_addr(wp_r, leader_r);
    score_re       = 1'b0;
    score_we       = 1'b0;
    score_ra       = '0;
    score_wd       = score_inc;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sym_nxt = in_sample[SYMBOL_WIDTH-1:0];
          hit_nxt = 1'b0;
          if (in_start_req) begin
            // new sequence: drop everything, symbol only enters history
            fill_nxt       = '0;
            leader_nxt     = '0;
            lead_score_nxt = '0;
            total_nxt      = '0;
            run_nxt        = '0;
            best_nxt       = '0;
            valid_nxt      = '0;
            state_nxt      = S_PUSH;
          end else if (fill_r == '0) begin
            state_nxt = S_PUSH;
          end else begin
            hist_re   = 1'b1;   // symbol at the leading lag
            state_nxt = S_CHK;
          end
        end
      end

      S_CHK: begin
        if (match) begin
          hit_nxt   = 1'b1;
          total_nxt = sat_inc(total_r);
          run_nxt   = sat_inc(run_r);
          if (sat_inc(run_r) > best_r) begin
            best_nxt = sat_inc(run_r);
          end
        end else begin
          run_nxt = '0;
        end
        // issue offset 0
        off_nxt   = '0;
        hist_re   = 1'b1;
        hist_ra   = hist_addr(wp_r, '0);
        score_re  = 1'b1;
        score_ra  = '0;
        state_nxt = S_WALK;
      end

      S_WALK: begin
        if (match) begin
          score_we          = 1'b1;
          score_ra          = off_r;
          valid_nxt[off_r]  = 1'b1;
          // lead_score_r always holds the leader's score
          if (score_inc >= lead_score_r) begin
            leader_nxt     = off_r;
            lead_score_nxt = score_inc;
          end
        end
        if (off_inc < (LAG_W+1)'(fill_r)) begin
          off_nxt  = off_inc[LAG_W-1:0];
          hist_re  = 1'b1;
          hist_ra  = hist_addr(wp_r, off_inc[LAG_W-1:0]);
          score_re = 1'b1;
          score_ra = off_inc[LAG_W-1:0];
        end else begin
          state_nxt = S_PUSH;
        end
      end

      S_PUSH: begin
        if (out_free) begin
          hist_we       = 1'b1;
          wp_nxt        = wp_inc(wp_r);
          if (fill_r < fill_t'(MAX_LAG)) begin
            fill_nxt = fill_r + 1'b1;
          end
          out_valid_nxt = 1'b1;
          out_hit_nxt   = hit_r;
          out_total_nxt = total_r;
          out_best_nxt  = best_r;
          out_lead_nxt  = leader_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Score write address is the offset being processed; reads run one ahead.
  always_ff @(posedge clk) begin
    if (score_we) begin
      score_mem[off_r] <= score_wd;
    end
    if (score_re) begin
      score_rd_r <= score_mem[score_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[wp_r] <= sym_r;
    end
    if (hist_re) begin
      hist_rd_r <= hist_mem[hist_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      wp_r         <= '0;
      off_r        <= '0;
      leader_r     <= '0;
      lead_score_r <= '0;
      total_r      <= '0;
      run_r        <= '0;
      best_r       <= '0;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      wp_r         <= wp_nxt;
      off_r        <= off_nxt;
      leader_r     <= leader_nxt;
      lead_score_r <= lead_score_nxt;
      total_r      <= total_nxt;
      run_r        <= run_nxt;
      best_r       <= best_nxt;
      valid_r      <= valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r       <= sym_nxt;
    hit_r       <= hit_nxt;
    out_hit_r   <= out_hit_nxt;
    out_total_r <= out_total_nxt;
    out_best_r  <= out_best_nxt;
    out_lead_r  <= out_lead_nxt;
  end

endmodule

>>> design/lps_checker.sv
// Port-level checks for the lag predictor scoreboard, bound to the top level.
// Depends on lag_predictor_scoreboard ports only.
module lps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_hit,
  input logic [31:0] out_hit_total,
  input logic [31:0] out_best_run,
  input logic [6:0]  out_lead_offset
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit) &&
      $stable(out_hit_total) && $stable(out_best_run) && $stable(out_lead_offset))
    else $error("stalled result changed");

  // one item at a time: an accepted item blocks the input the next cycle
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while item in flight");

  // a correct prediction shows in both counters
  a_hit_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> (out_hit_total != 32'd0) && (out_best_run != 32'd0))
    else $error("hit without counts");

  // a new result appears only while an item is in flight
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without item");

endmodule

bind lag_predictor_scoreboard lps_checker u_lps_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_hit        (out_hit),
  .out_hit_total  (out_hit_total),
  .out_best_run   (out_best_run),
  .out_lead_offset(out_lead_offset)
);
